FILE: rtl/core/assert_macros.svh
// assertion helpers, included by string_hash_with_array_index
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/shidx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shidx_pkg
// Types and constants for the string hash / array index block.
// ----------------------------------------------------------------------------
package shidx_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned HASH_W = 32;

  localparam logic [HASH_W-1:0] HASH_SEED   = 32'hFFFF_FFFF;
  localparam logic [HASH_W-1:0] HASH_MARK   = 32'hF000_0000;
  localparam logic [HASH_W-1:0] INDEX_LIMIT = 32'hFFFF_FFFF;
  localparam logic [HASH_W-1:0] INDEX_CLAMP = 32'h7FFF_FFFF;
  localparam logic [UNIT_W-1:0] DIGIT_BASE  = 16'h0030;
  localparam logic [UNIT_W-1:0] DIGIT_MAX   = 16'd9;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [HASH_W-1:0] index;
    logic              idx_ok;
    logic              first;
    logic              lead_zero;
  } shidx_state_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic              is_array_index;
  } shidx_res_t;

  localparam shidx_state_t STATE_CLEAR = '{
    hash:      HASH_SEED,
    index:     '0,
    idx_ok:    1'b1,
    first:     1'b1,
    lead_zero: 1'b0
  };

endpackage

FILE: rtl/core/shidx_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shidx_in_if
// Input channel: one code unit per word, with a last-unit flag.
// ----------------------------------------------------------------------------
interface shidx_in_if import shidx_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  logic              last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

FILE: rtl/core/shidx_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shidx_out_if
// Result channel: hash or array index per string.
// ----------------------------------------------------------------------------
interface shidx_out_if import shidx_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;
  logic              is_array_index;

  modport source (output valid, output hash_value, output is_array_index, input ready);
  modport sink   (input valid, input hash_value, input is_array_index, output ready);
endinterface

FILE: rtl/core/string_hash_with_array_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_with_array_index
// Streams a string's code units and returns its hash or array index.
// ----------------------------------------------------------------------------
// One code unit is taken per clock with no gaps needed between units or
// strings. A unit is held in an input register while the base-31 hash and
// the decimal index are updated by a combinational shift-add
// multiply-accumulate; on the last unit the result lands in an output
// register. The output register frees the input side: new units keep
// flowing while a finished result waits for the sink, and only the last
// unit of the next string stalls if the previous result has still not
// been taken.
module string_hash_with_array_index import shidx_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  shidx_in_if.sink    in_ch,
  shidx_out_if.source out_ch
);

  logic              s1_valid_r;
  logic [UNIT_W-1:0] s1_unit_r;
  logic              s1_last_r;
  shidx_state_t      st_r;
  shidx_state_t      st_nxt;
  shidx_res_t        res;
  logic              out_valid_r;
  shidx_res_t        out_r;
  logic              out_free;
  logic              s1_move;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_move      = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready  = !s1_valid_r || s1_move;

  shidx_step u_step (
    .st        (st_r),
    .code_unit (s1_unit_r),
    .last_unit (s1_last_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_unit_r <= in_ch.code_unit;
      s1_last_r <= in_ch.last_unit;
    end
  end

  // running string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_CLEAR;
    end else if (s1_move) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_last_r) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hash_value     = out_r.hash_value;
  assign out_ch.is_array_index = out_r.is_array_index;

`include "assert_macros.svh"

  `ASSERT_CLK(a_idx_clamped,
    (out_valid_r && out_r.is_array_index) |-> !out_r.hash_value[HASH_W-1],
    "index result above clamp")
  `ASSERT_CLK(a_hash_marked,
    (out_valid_r && !out_r.is_array_index)
      |-> (out_r.hash_value[HASH_W-1:HASH_W-4] == 4'hF),
    "hash result missing top mark")
  `ASSERT_CLK(a_state_cleared,
    (s1_move && s1_last_r) |=> (st_r == STATE_CLEAR),
    "state not cleared after last unit")
  `ASSERT_CLK(a_no_result_drop,
    (out_valid_r && !out_ch.ready) |-> !(s1_move && s1_last_r),
    "result overwritten while stalled")

endmodule

FILE: rtl/core/shidx_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shidx_step
// Next-state and result logic for one code unit.
// ----------------------------------------------------------------------------
module shidx_step import shidx_pkg::*; (
  input  shidx_state_t      st,
  input  logic [UNIT_W-1:0] code_unit,
  input  logic              last_unit,
  output shidx_state_t      st_nxt,
  output shidx_res_t        res
);

  logic [UNIT_W-1:0] digit;
  logic              not_digit;
  logic [HASH_W-1:0] hash_upd;
  logic [HASH_W+3:0] idx_mac;
  shidx_state_t      upd;
  logic              idx_final;

  assign digit     = code_unit - DIGIT_BASE;
  assign not_digit = digit > DIGIT_MAX;

  // 31*h = 32*h - h
  assign hash_upd = (st.hash << 5) - st.hash + {{(HASH_W-UNIT_W){1'b0}}, code_unit};

  // 10*i = 8*i + 2*i, kept wide enough to see the carry out
  assign idx_mac = ({4'b0, st.index} << 3) + ({4'b0, st.index} << 1)
                 + {{(HASH_W-UNIT_W+4){1'b0}}, digit};

  always_comb begin
    upd       = st;
    upd.hash  = hash_upd;
    upd.first = 1'b0;
    if (st.idx_ok) begin
      if (not_digit) begin
        upd.idx_ok = 1'b0;
      end else if (st.first) begin
        upd.index     = {{(HASH_W-UNIT_W){1'b0}}, digit};
        upd.lead_zero = (digit == '0);
      end else if (st.lead_zero) begin
        upd.idx_ok = 1'b0;
      end else if (|idx_mac[HASH_W+3:HASH_W]) begin
        upd.idx_ok = 1'b0;
      end else begin
        upd.index = idx_mac[HASH_W-1:0];
      end
    end
  end

  assign idx_final = upd.idx_ok && (upd.index != INDEX_LIMIT);

  always_comb begin
    res.is_array_index = idx_final;
    if (idx_final) begin
      res.hash_value = upd.index[HASH_W-1] ? INDEX_CLAMP : upd.index;
    end else begin
      res.hash_value = upd.hash | HASH_MARK;
    end
  end

  assign st_nxt = last_unit ? STATE_CLEAR : upd;

endmodule
